/* rtl/c8_pkg.sv */
`default_nettype none
package c8_pkg;

    localparam logic [11:0] PC_START  = 12'h200;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam int          FONT_LEN  = 80;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_EXEC  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] mem_address;
        logic [7:0]  mem_byte;
        logic [4:0]  display_row;
    } c8_in_t;

    typedef struct packed {
        logic        status;
        logic [15:0] opcode_run;
        logic [11:0] next_pc;
        logic        drew;
        logic [7:0]  flag_reg;
        logic [63:0] row_pixels;
    } c8_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_DECODE,
        ST_DRAW_RD,
        ST_DRAW_ROW,
        ST_DRAW_WR,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } c8_state_t;

    // Bus from sequencer to the frame buffer.
    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [63:0] wdata;
    } c8_fb_req_t;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] f [0:79];
        f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (idx < 7'(FONT_LEN))
            font_byte = f[idx];
        else
            font_byte = 8'h00;
    endfunction

endpackage
`default_nettype wire

/* rtl/c8_ram.sv */
`default_nettype none
module c8_ram (
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [11:0] addr,
    input  wire logic [7:0]  wdata,
    output logic      [7:0]  rdata
);
    logic [7:0] mem [0:4095];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* rtl/c8_frame.sv */
`default_nettype none
module c8_frame (
    input  wire logic               clk,
    input  wire c8_pkg::c8_fb_req_t req,
    output logic [63:0]             rdata
);
    import c8_pkg::*;

    logic [63:0] rows [0:31];

    always_ff @(posedge clk)
    begin
        if (req.we)
            rows[req.addr] <= req.wdata;
        rdata <= rows[req.addr];
    end
endmodule
`default_nettype wire

/* rtl/chip8_instruction_step_core.sv */
`default_nettype none
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | c8_in_t
// out     | output    | out_valid/out_ready | c8_out_t
// An item runs from accept until its result is taken; 00E0 clears one frame row per cycle,
// and DXYN works only the rows left after clipping at the bottom of the frame
// (one RAM read, one frame read and one frame write per sprite row, single ports).
// After reset a clearing pass zeroes all 4096 RAM bytes and loads the font,
// then clears all 32 frame rows; no item is taken meanwhile.
// One item at a time; in_ready is low from accept until the result is taken.
module chip8_instruction_step_core #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire c8_pkg::c8_in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output c8_pkg::c8_out_t      out_data
);
    import c8_pkg::*;

    localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    c8_state_t state_reg, state_next;

    logic [12:0] cnt_reg, cnt_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] idx_reg, idx_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]  v_reg [0:15];
    logic [11:0] stk_reg [0:STACK_DEPTH-1];
    logic [15:0] op_reg, op_next;
    logic [5:0]  xp_reg, xp_next;
    logic [4:0]  yrow_reg, yrow_next;
    logic [63:0] mask_reg, mask_next;
    logic        hit_reg, hit_next;
    logic        status_reg, status_next;
    logic        drew_reg, drew_next;
    logic [63:0] pix_reg, pix_next;

    logic        ram_we;
    logic [11:0] ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;
    c8_fb_req_t  fb_req;
    logic [63:0] fb_rdata;

    logic        v_we;
    logic [3:0]  v_widx;
    logic [7:0]  v_wdata;
    logic        vf_we;
    logic [7:0]  vf_wdata;
    logic        stk_we;

    c8_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    c8_frame u_frame (
        .clk   (clk),
        .req   (fb_req),
        .rdata (fb_rdata)
    );

    logic [3:0] opx, opy, opn;
    logic [7:0] vx, vy, nn;
    logic [8:0] sum9;
    logic [5:0] col_w;
    logic [63:0] row_mask;

    always_comb
    begin
        opx  = op_reg[11:8];
        opy  = op_reg[7:4];
        opn  = op_reg[3:0];
        nn   = op_reg[7:0];
        vx   = v_reg[opx];
        vy   = v_reg[opy];
        sum9 = {1'b0, vx} + {1'b0, (op_reg[15:12] == 4'h7) ? nn : vy};
        row_mask = '0;
        for (int c = 0; c < 8; c++)
        begin
            col_w = xp_reg + 6'(c);
            if ((7'(xp_reg) + 7'(c) < 7'd64) && ram_rdata[7-c])
                row_mask[6'd63 - col_w] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                if (cnt_reg == 13'd4127)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                begin
                    priority if (in_data.func == FUNC_EXEC)
                        state_next = ST_FETCH_HI;
                    else if (in_data.func == FUNC_READ)
                        state_next = ST_READ;
                    else
                        state_next = ST_DONE;
                end
            ST_FETCH_HI: state_next = ST_FETCH_LO;
            ST_FETCH_LO: state_next = ST_DECODE;
            ST_DECODE:
                priority if (op_reg[15:12] == 4'hD)
                    state_next = (opn == 4'd0) ? ST_DONE : ST_DRAW_RD;
                else if (op_reg[15:12] == 4'h0 && nn == 8'hE0)
                    state_next = ST_CLEAR;
                else
                    state_next = ST_DONE;
            ST_DRAW_RD:  state_next = ST_DRAW_ROW;
            ST_DRAW_ROW: state_next = ST_DRAW_WR;
            ST_DRAW_WR:
                if (cnt_reg[3:0] + 4'd1 == opn || yrow_reg == 5'd31)
                    state_next = ST_DONE;
                else
                    state_next = ST_DRAW_RD;
            ST_CLEAR:
                if (cnt_reg[4:0] == 5'd31)
                    state_next = ST_DONE;
            ST_READ: state_next = ST_DONE;
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        pc_next     = pc_reg;
        idx_next    = idx_reg;
        sp_next     = sp_reg;
        op_next     = op_reg;
        xp_next     = xp_reg;
        yrow_next   = yrow_reg;
        mask_next   = mask_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        drew_next   = drew_reg;
        pix_next    = pix_reg;
        ram_we      = 1'b0;
        ram_addr    = pc_reg;
        ram_wdata   = 8'h00;
        fb_req      = '{we: 1'b0, addr: yrow_reg, wdata: 64'd0};
        v_we        = 1'b0;
        v_widx      = opx;
        v_wdata     = 8'h00;
        vf_we       = 1'b0;
        vf_wdata    = 8'h00;
        stk_we      = 1'b0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg < 13'd4096)
                begin
                    ram_we    = 1'b1;
                    ram_addr  = cnt_reg[11:0];
                    ram_wdata = 8'h00;
                    if (cnt_reg[11:0] >= FONT_BASE &&
                        cnt_reg[11:0] < FONT_BASE + 12'(FONT_LEN))
                        ram_wdata = font_byte(7'(cnt_reg[11:0] - FONT_BASE));
                end
                else
                    fb_req = '{we: 1'b1, addr: cnt_reg[4:0], wdata: 64'd0};
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                status_next = 1'b0;
                drew_next   = 1'b0;
                pix_next    = '0;
                op_next     = '0;
                hit_next    = 1'b0;
                cnt_next    = '0;
                if (in_valid && in_data.func == FUNC_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_addr  = in_data.mem_address;
                    ram_wdata = in_data.mem_byte;
                end
                if (in_valid && in_data.func == FUNC_READ)
                    fb_req.addr = in_data.display_row;
            end
            ST_FETCH_HI:
            begin
                ram_addr      = pc_reg + 12'd1;
                op_next[15:8] = ram_rdata;
            end
            ST_FETCH_LO:
                op_next[7:0] = ram_rdata;
            ST_DECODE:
            begin
                pc_next  = pc_reg + 12'd2;
                xp_next  = vx[5:0];
                yrow_next = vy[4:0];
                unique case (op_reg[15:12])
                    4'h0:
                        if (nn == 8'hE0)
                            drew_next = 1'b1;
                        else if (nn == 8'hEE)
                        begin
                            sp_next = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1)
                                                     : sp_reg - SPW'(1);
                            pc_next = stk_reg[sp_next];
                        end
                    4'h1: pc_next = op_reg[11:0];
                    4'h2:
                    begin
                        stk_we  = 1'b1;
                        sp_next = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0
                                                                    : sp_reg + SPW'(1);
                        pc_next = op_reg[11:0];
                    end
                    4'h3: if (vx == nn) pc_next = pc_reg + 12'd4;
                    4'h4: if (vx != nn) pc_next = pc_reg + 12'd4;
                    4'h5: if (vx == vy) pc_next = pc_reg + 12'd4;
                    4'h9: if (vx != vy) pc_next = pc_reg + 12'd4;
                    4'h6: begin v_we = 1'b1; v_wdata = nn; end
                    4'h7: begin v_we = 1'b1; v_wdata = sum9[7:0]; end
                    4'h8:
                    begin
                        v_we = (opn <= 4'd4);
                        unique case (opn)
                            4'd0: v_wdata = vy;
                            4'd1: v_wdata = vx | vy;
                            4'd2: v_wdata = vx & vy;
                            4'd3: v_wdata = vx ^ vy;
                            4'd4:
                            begin
                                v_wdata  = sum9[7:0];
                                vf_we    = 1'b1;
                                vf_wdata = {7'd0, sum9[8]};
                            end
                            default: v_wdata = vx;
                        endcase
                    end
                    4'hA: idx_next = op_reg[11:0];
                    4'hD:
                    begin
                        drew_next = 1'b1;
                        if (opn == 4'd0)
                        begin
                            vf_we = 1'b1;
                        end
                    end
                    default: status_next = 1'b1;
                endcase
            end
            ST_DRAW_RD:
            begin
                ram_addr = idx_reg + 12'(cnt_reg[3:0]);
            end
            ST_DRAW_ROW:
            begin
                mask_next = row_mask;
            end
            ST_DRAW_WR:
            begin
                if ((fb_rdata & mask_reg) != 64'd0)
                    hit_next = 1'b1;
                fb_req   = '{we: 1'b1, addr: yrow_reg, wdata: fb_rdata ^ mask_reg};
                cnt_next = cnt_reg + 13'd1;
                yrow_next = yrow_reg + 5'd1;
                if (cnt_reg[3:0] + 4'd1 == opn || yrow_reg == 5'd31)
                begin
                    vf_we    = 1'b1;
                    vf_wdata = {7'd0, hit_next};
                end
            end
            ST_CLEAR:
            begin
                fb_req   = '{we: 1'b1, addr: cnt_reg[4:0], wdata: 64'd0};
                cnt_next = cnt_reg + 13'd1;
            end
            ST_READ:
                pix_next = fb_rdata;
            ST_DONE:
                out_valid = 1'b1;
            default: ;
        endcase
    end

    // Frame read for DRAW_WR: row address held stable through RD and ROW.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            pc_reg    <= PC_START;
            idx_reg   <= '0;
            sp_reg    <= '0;
            for (int i = 0; i < 16; i++)
                v_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            // VF write wins over a data write to VF
            if (v_we && !(vf_we && v_widx == 4'd15))
                v_reg[v_widx] <= v_wdata;
            if (vf_we)
                v_reg[15] <= vf_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_reg[sp_reg] <= pc_reg + 12'd2;
        if (state_reg == ST_IDLE || state_reg == ST_FETCH_HI || state_reg == ST_FETCH_LO)
            op_reg <= op_next;
        xp_reg     <= xp_next;
        yrow_reg   <= yrow_next;
        mask_reg   <= mask_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        drew_reg   <= drew_next;
        pix_reg    <= pix_next;
    end

    assign out_data = '{
        status:     status_reg,
        opcode_run: op_reg,
        next_pc:    pc_reg,
        drew:       drew_reg,
        flag_reg:   v_reg[15],
        row_pixels: pix_reg
    };
endmodule
`default_nettype wire
